>>> src/afcl_pkg.sv
// Shared types and constants for the aspect-fit centre layout block.
package afcl_pkg;

  localparam int DIM_W  = 16;
  localparam int PROD_W = 2 * DIM_W;
  localparam int DIV_STEPS = DIM_W;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 16'd320;
  localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 16'd480;

  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [PROD_W-1:0] prod_t;

  // one request as it moves through the divider row
  typedef struct packed {
    logic  ok;     // request is valid
    logic  fits;   // source kept at its own size
    logic  wside;  // width is the limiting side
    dim_t  bx;
    dim_t  by;
    dim_t  cw;
    dim_t  ch;
    dim_t  sw;
    dim_t  sh;
    dim_t  den;
    prod_t work;   // {partial remainder, dividend bits / quotient bits}
  } job_t;

  typedef struct packed {
    logic busy;
    job_t job;
  } stage_t;

endpackage

>>> src/afcl_if.sv
// Request and result channel interfaces.
interface afcl_req_if;
  import afcl_pkg::*;
  logic valid;
  logic ready;
  dim_t source_width;
  dim_t source_height;
  dim_t box_left;
  dim_t box_top;
  dim_t box_span_x;
  dim_t box_span_y;

  modport source (output valid, source_width, source_height, box_left, box_top,
                  box_span_x, box_span_y, input ready);
  modport sink (input valid, source_width, source_height, box_left, box_top,
                box_span_x, box_span_y, output ready);
endinterface

interface afcl_res_if;
  import afcl_pkg::*;
  logic valid;
  logic ready;
  logic layout_valid;
  dim_t draw_left;
  dim_t draw_top;
  dim_t draw_span_x;
  dim_t draw_span_y;
  dim_t clipped_span_x;
  dim_t clipped_span_y;

  modport source (output valid, layout_valid, draw_left, draw_top, draw_span_x,
                  draw_span_y, clipped_span_x, clipped_span_y, input ready);
  modport sink (input valid, layout_valid, draw_left, draw_top, draw_span_x,
                draw_span_y, clipped_span_x, clipped_span_y, output ready);
endinterface

>>> src/aspect_fit_center_layout_top.sv
// Aspect-fit centre layout: a new request may be accepted every cycle unless a
// result-side stall has backed the row up, and each one passes 20 register stages:
// three front stages (clip, cross products, operand select), a row of 16 divide
// cells that each settle one quotient bit, and the result register. A result-side
// stall holds only the full stages, so bubbles in the row are filled before the
// input stalls.
// Screen size registers reset to 320 x 480 and should be written only while idle.
module aspect_fit_center_layout_top import afcl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  afcl_req_if.sink             req,
  afcl_res_if.source           res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  dim_t                 cfg_data
);

  dim_t   screen_width, screen_height;
  stage_t chain [0:DIV_STEPS];
  logic   chain_en [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  afcl_front u_front (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .down_en       (chain_en[0]),
    .dn            (chain[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    afcl_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .up      (chain[i]),
      .up_en   (chain_en[i]),
      .down_en (chain_en[i+1]),
      .dn      (chain[i+1])
    );
  end

  afcl_back u_back (
    .clk   (clk),
    .rst   (rst),
    .up    (chain[DIV_STEPS]),
    .up_en (chain_en[DIV_STEPS]),
    .res   (res)
  );

endmodule

>>> src/afcl_front.sv
// Front end: clip to screen, cross products, pick the divide operands.
module afcl_front import afcl_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  afcl_req_if.sink req,
  input  dim_t   screen_width,
  input  dim_t   screen_height,
  input  logic   down_en,
  output stage_t dn
);

  typedef struct packed {
    logic ok;
    dim_t bx;
    dim_t by;
    dim_t cw;
    dim_t ch;
    dim_t sw;
    dim_t sh;
  } clip_t;

  typedef struct packed {
    clip_t c;
    prod_t pw;   // sw * ch
    prod_t ph;   // sh * cw
  } mult_t;

  logic  busy1, busy2, busy3;
  clip_t s1, s1_next;
  mult_t s2, s2_next;
  job_t  s3, s3_next;
  logic  en1, en2, en3;
  dim_t  avail_x, avail_y;
  logic  fits, wside;

  assign en3 = !busy3 || down_en;
  assign en2 = !busy2 || en3;
  assign en1 = !busy1 || en2;
  assign req.ready = en1;

  always_comb begin
    avail_x = screen_width - req.box_left;
    avail_y = screen_height - req.box_top;
    s1_next.ok = (req.source_width != '0) && (req.source_height != '0) &&
                 (req.box_span_x != '0) && (req.box_span_y != '0) &&
                 (req.box_left < screen_width) && (req.box_top < screen_height);
    s1_next.bx = req.box_left;
    s1_next.by = req.box_top;
    s1_next.cw = (avail_x > req.box_span_x) ? req.box_span_x : avail_x;
    s1_next.ch = (avail_y > req.box_span_y) ? req.box_span_y : avail_y;
    s1_next.sw = req.source_width;
    s1_next.sh = req.source_height;
  end

  always_comb begin
    s2_next.c  = s1;
    s2_next.pw = prod_t'(s1.sw) * prod_t'(s1.ch);
    s2_next.ph = prod_t'(s1.sh) * prod_t'(s1.cw);
  end

  always_comb begin
    fits  = (s2.c.sw <= s2.c.cw) && (s2.c.sh <= s2.c.ch);
    wside = s2.pw >= s2.ph;
    s3_next.ok    = s2.c.ok;
    s3_next.fits  = fits;
    s3_next.wside = wside;
    s3_next.bx    = s2.c.bx;
    s3_next.by    = s2.c.by;
    s3_next.cw    = s2.c.cw;
    s3_next.ch    = s2.c.ch;
    s3_next.sw    = s2.c.sw;
    s3_next.sh    = s2.c.sh;
    // quotient never exceeds the clipped span, so the top half is below den
    if (!s2.c.ok || fits) begin
      s3_next.den  = dim_t'(1);
      s3_next.work = '0;
    end else if (wside) begin
      s3_next.den  = s2.c.sw;
      s3_next.work = s2.ph;
    end else begin
      s3_next.den  = s2.c.sh;
      s3_next.work = s2.pw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy1 <= 1'b0;
      busy2 <= 1'b0;
      busy3 <= 1'b0;
    end else begin
      if (en1) busy1 <= req.valid;
      if (en2) busy2 <= busy1;
      if (en3) busy3 <= busy2;
    end
    if (en1) s1 <= s1_next;
    if (en2) s2 <= s2_next;
    if (en3) s3 <= s3_next;
  end

  assign dn.busy = busy3;
  assign dn.job  = s3;

endmodule

>>> src/afcl_div_cell.sv
// One restoring-divide cell: yields one quotient bit per beat.
module afcl_div_cell import afcl_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  stage_t up,
  output logic   up_en,
  input  logic   down_en,
  output stage_t dn
);

  logic           busy;
  job_t           job, job_next;
  logic [DIM_W:0] trial;
  logic           ge;
  dim_t           rem;

  assign up_en = !busy || down_en;

  always_comb begin
    trial = up.job.work[PROD_W-1:DIM_W-1];
    ge    = trial >= {1'b0, up.job.den};
    rem   = ge ? dim_t'(trial - {1'b0, up.job.den}) : trial[DIM_W-1:0];
    job_next      = up.job;
    job_next.work = {rem, up.job.work[DIM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (up_en) begin
      busy <= up.busy;
    end
    if (up_en) job <= job_next;
  end

  assign dn.busy = busy;
  assign dn.job  = job;

endmodule

>>> src/afcl_back.sv
// Back end: drawn size, centring and the result register.
module afcl_back import afcl_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  stage_t up,
  output logic   up_en,
  afcl_res_if.source res
);

  dim_t q, dw, dh, dw_raw, dh_raw;
  logic valid_r;
  logic lv;
  dim_t dl, dt, dsx, dsy, csx, csy;

  assign up_en = !valid_r || res.ready;

  always_comb begin
    q = up.job.work[DIM_W-1:0];
    if (up.job.fits) begin
      dw_raw = up.job.sw;
      dh_raw = up.job.sh;
    end else if (up.job.wside) begin
      dw_raw = up.job.cw;
      dh_raw = q;
    end else begin
      dw_raw = q;
      dh_raw = up.job.ch;
    end
    dw = (dw_raw == '0) ? dim_t'(1) : dw_raw;
    dh = (dh_raw == '0) ? dim_t'(1) : dh_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r <= 1'b0;
    end else if (up_en) begin
      valid_r <= up.busy;
    end
    if (up_en) begin
      if (up.job.ok) begin
        lv  <= 1'b1;
        dl  <= up.job.bx + ((up.job.cw - dw) >> 1);
        dt  <= up.job.by + ((up.job.ch - dh) >> 1);
        dsx <= dw;
        dsy <= dh;
        csx <= up.job.cw;
        csy <= up.job.ch;
      end else begin
        lv  <= 1'b0;
        dl  <= '0;
        dt  <= '0;
        dsx <= '0;
        dsy <= '0;
        csx <= '0;
        csy <= '0;
      end
    end
  end

  assign res.valid          = valid_r;
  assign res.layout_valid   = lv;
  assign res.draw_left      = dl;
  assign res.draw_top       = dt;
  assign res.draw_span_x    = dsx;
  assign res.draw_span_y    = dsy;
  assign res.clipped_span_x = csx;
  assign res.clipped_span_y = csy;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the aspect-fit centre layout block.
module testbench;
  import afcl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;  // cycles with no beat before giving up
  localparam int HOLD_CYCLES = 300;   // long result-side hold-off
  localparam int SETTLE      = 30;    // pipeline latency plus margin

  typedef struct packed {
    dim_t sw;
    dim_t sh;
    dim_t bx;
    dim_t by;
    dim_t rx;
    dim_t ry;
  } layout_req_t;

  typedef struct packed {
    logic ok;
    dim_t left;
    dim_t top;
    dim_t span_x;
    dim_t span_y;
    dim_t clip_x;
    dim_t clip_y;
  } layout_res_t;

  class layout_scoreboard;
    dim_t        scr_w;
    dim_t        scr_h;
    layout_res_t layouts_due[$];
    int          errors;
    int          n_requests;
    int          n_rejected;
    int          n_scaled;

    function new();
      scr_w = SCREEN_WIDTH_RST;
      scr_h = SCREEN_HEIGHT_RST;
    endfunction

    function void set_screen(logic [CFG_IDX_W-1:0] idx, dim_t value);
      if (idx == REG_SCREEN_WIDTH) scr_w = value;
      else if (idx == REG_SCREEN_HEIGHT) scr_h = value;
    endfunction

    function int pending();
      return layouts_due.size();
    endfunction

    // clip the box, fit the source keeping its aspect ratio, centre it
    function layout_res_t fit_layout(layout_req_t r);
      layout_res_t o;
      bit [31:0] cw, ch, dw, dh, w_by_ch, h_by_cw;
      o = '0;
      if (r.sw == 0 || r.sh == 0 || r.rx == 0 || r.ry == 0 ||
          r.bx >= scr_w || r.by >= scr_h) begin
        n_rejected++;
        return o;
      end
      cw = 32'(scr_w) - 32'(r.bx);
      if (cw > 32'(r.rx)) cw = 32'(r.rx);
      ch = 32'(scr_h) - 32'(r.by);
      if (ch > 32'(r.ry)) ch = 32'(r.ry);
      w_by_ch = 32'(r.sw) * ch;
      h_by_cw = 32'(r.sh) * cw;
      if (32'(r.sw) <= cw && 32'(r.sh) <= ch) begin
        dw = 32'(r.sw);
        dh = 32'(r.sh);
      end else if (w_by_ch >= h_by_cw) begin
        n_scaled++;
        dw = cw;
        dh = h_by_cw / 32'(r.sw);
      end else begin
        n_scaled++;
        dh = ch;
        dw = w_by_ch / 32'(r.sh);
      end
      if (dw == 0) dw = 1;
      if (dh == 0) dh = 1;
      o.ok     = 1'b1;
      o.left   = dim_t'(32'(r.bx) + (cw - dw) / 2);
      o.top    = dim_t'(32'(r.by) + (ch - dh) / 2);
      o.span_x = dim_t'(dw);
      o.span_y = dim_t'(dh);
      o.clip_x = dim_t'(cw);
      o.clip_y = dim_t'(ch);
      return o;
    endfunction

    function void note_request(layout_req_t r);
      n_requests++;
      layouts_due.push_back(fit_layout(r));
    endfunction

    // four-state compare so an unknown output counts as a mismatch
    function void check_field(string name, logic [DIM_W-1:0] want, logic [DIM_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(layout_res_t got);
      layout_res_t want;
      if (layouts_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, expected none, actual %p",
                 $time, got);
        return;
      end
      want = layouts_due.pop_front();
      check_field("layout_valid", want.ok, got.ok);
      check_field("draw_left", want.left, got.left);
      check_field("draw_top", want.top, got.top);
      check_field("draw_span_x", want.span_x, got.span_x);
      check_field("draw_span_y", want.span_y, got.span_y);
      check_field("clipped_span_x", want.clip_x, got.clip_x);
      check_field("clipped_span_y", want.clip_y, got.clip_y);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  dim_t                 cfg_data;

  afcl_req_if req_ch ();
  afcl_res_if res_ch ();

  aspect_fit_center_layout_top dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  layout_scoreboard sb = new();
  bit hold_req;
  int n_settings;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = REG_SCREEN_WIDTH;
    cfg_data             = '0;
    req_ch.valid         = 1'b0;
    req_ch.source_width  = '0;
    req_ch.source_height = '0;
    req_ch.box_left      = '0;
    req_ch.box_top       = '0;
    req_ch.box_span_x    = '0;
    req_ch.box_span_y    = '0;
    res_ch.ready         = 1'b0;
    hold_req             = 1'b0;
  end

  // mostly short gaps, plenty of zero, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // result side: random ready pattern, with a long hold-off on request
  initial begin
    int on_len;
    int gap;
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      on_len = $urandom_range(1, 20);
      res_ch.ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      sb.note_request('{req_ch.source_width, req_ch.source_height, req_ch.box_left,
                        req_ch.box_top, req_ch.box_span_x, req_ch.box_span_y});
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result('{res_ch.layout_valid, res_ch.draw_left, res_ch.draw_top,
                        res_ch.draw_span_x, res_ch.draw_span_y,
                        res_ch.clipped_span_x, res_ch.clipped_span_y});
  end

  initial begin
    int idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("%0t: no beat for %0d cycles, outstanding %0d", $time, STALL_LIMIT,
             sb.pending());
    $display("testbench NOT OK");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, dim_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_screen(idx, value);
  endtask

  task automatic set_screen(dim_t w, dim_t h);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic idle_sender(int cycles);
    if (cycles > 0) begin
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // valid stays high across back-to-back beats; idle_sender lowers it
  task automatic push_request(layout_req_t r);
    req_ch.valid         <= 1'b1;
    req_ch.source_width  <= r.sw;
    req_ch.source_height <= r.sh;
    req_ch.box_left      <= r.bx;
    req_ch.box_top       <= r.by;
    req_ch.box_span_x    <= r.rx;
    req_ch.box_span_y    <= r.ry;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic send(dim_t sw, dim_t sh, dim_t bx, dim_t by, dim_t rx, dim_t ry);
    idle_sender(pick_gap());
    push_request('{sw, sh, bx, by, rx, ry});
  endtask

  task automatic wait_for_results();
    idle_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic dim_t rand_size(int near);
    int lo;
    int hi;
    if (near < 1) near = 1;
    case ($urandom_range(0, 3))
      0: return dim_t'($urandom_range(1, 16));
      1: return dim_t'($urandom_range(1, 2048));
      2: return dim_t'($urandom_range(1, 65535));
      default: begin
        lo = (near > 8) ? near - 8 : 1;
        hi = (near < 65527) ? near + 8 : 65535;
        return dim_t'($urandom_range(lo, hi));
      end
    endcase
  endfunction

  function automatic dim_t rand_corner(dim_t scr);
    int p;
    if (scr == 0) return dim_t'($urandom_range(0, 65535));
    p = $urandom_range(0, 99);
    if (p < 10) return '0;
    if (p < 20) return scr - 1;
    return dim_t'($urandom_range(0, scr - 1));
  endfunction

  // mostly requests that reach the scaling logic, some broken ones
  function automatic layout_req_t make_request();
    layout_req_t r;
    int p;
    r.bx = rand_corner(sb.scr_w);
    r.by = rand_corner(sb.scr_h);
    r.rx = rand_size(int'(sb.scr_w) - int'(r.bx));
    r.ry = rand_size(int'(sb.scr_h) - int'(r.by));
    r.sw = rand_size(r.rx);
    r.sh = rand_size(r.ry);
    p = $urandom_range(0, 99);
    if (p < 3) r.sw = '0;
    else if (p < 6) r.sh = '0;
    else if (p < 9) r.rx = '0;
    else if (p < 12) r.ry = '0;
    else if (p < 15) r.bx = dim_t'($urandom_range(sb.scr_w, 65535));
    else if (p < 18) r.by = dim_t'($urandom_range(sb.scr_h, 65535));
    else if (p < 22) r = layout_req_t'({$urandom, $urandom, $urandom});
    return r;
  endfunction

  task automatic random_requests(int count, int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      // keep offering during the hold-off so the row fills and backs up
      idle_sender(hold_req ? 0 : pick_gap());
      push_request(make_request());
    end
    wait_for_results();
  endtask

  initial begin
    n_settings = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_screen(16'd320, 16'd480);
    send(16'd100, 16'd50, 16'd10, 16'd20, 16'd200, 16'd200);       // fits as is
    send(16'd640, 16'd480, 16'd0, 16'd0, 16'd320, 16'd480);        // width limits
    send(16'd100, 16'd1000, 16'd0, 16'd0, 16'd320, 16'd480);       // height limits
    send(16'd200, 16'd300, 16'd0, 16'd0, 16'd100, 16'd150);        // tie, width wins
    send(16'd65535, 16'd1, 16'd0, 16'd0, 16'd10, 16'd10);          // height rounds to 1
    send(16'd1, 16'd65535, 16'd0, 16'd0, 16'd10, 16'd10);          // width rounds to 1
    send(16'd50, 16'd50, 16'd300, 16'd400, 16'd100, 16'd100);      // clipped box
    send(16'd10, 16'd10, 16'd320, 16'd0, 16'd10, 16'd10);          // corner on edge
    send(16'd10, 16'd10, 16'd0, 16'd480, 16'd10, 16'd10);
    send(16'd65535, 16'd65535, 16'd319, 16'd479, 16'd65535, 16'd65535);
    send(16'd0, 16'd10, 16'd0, 16'd0, 16'd10, 16'd10);             // zero sizes
    send(16'd10, 16'd0, 16'd0, 16'd0, 16'd10, 16'd10);
    send(16'd10, 16'd10, 16'd0, 16'd0, 16'd0, 16'd10);
    send(16'd10, 16'd10, 16'd0, 16'd0, 16'd10, 16'd0);
    send(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send(16'd1, 16'd1, 16'd0, 16'd0, 16'd320, 16'd480);
    send(16'd3, 16'd3, 16'd0, 16'd0, 16'd10, 16'd10);              // odd margin
    random_requests(300, 60);

    set_screen(16'hffff, 16'hffff);
    send(16'hffff, 16'hffff, 16'd0, 16'd0, 16'hffff, 16'hffff);
    send(16'hffff, 16'hfffe, 16'hfffe, 16'd0, 16'hffff, 16'hffff);
    send(16'd7, 16'd7, 16'hffff, 16'd0, 16'd1, 16'd1);
    random_requests(300, -1);

    set_screen(16'd1, 16'd1);
    random_requests(150, -1);

    // a zero screen register rejects every box
    set_screen(16'd0, 16'd480);
    send(16'd10, 16'd10, 16'd0, 16'd0, 16'd10, 16'd10);
    random_requests(50, -1);
    set_screen(16'd640, 16'd0);
    send(16'd10, 16'd10, 16'd0, 16'd0, 16'd10, 16'd10);
    random_requests(50, -1);

    set_screen(dim_t'($urandom_range(1, 65535)), dim_t'($urandom_range(1, 65535)));
    random_requests(300, -1);

    set_screen(16'hffff, 16'd1);
    random_requests(150, -1);

    set_screen(16'd1920, 16'd1080);
    random_requests(200, -1);

    $display("covered %0d requests over %0d screen settings, long result stall included",
             sb.n_requests, n_settings);
    $display("%0d rejected, %0d scaled down, %0d mismatches", sb.n_rejected, sb.n_scaled,
             sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
